[rtl/ddmw_pkg.sv]
`timescale 1ns / 1ps

package ddmw_pkg;

	// Request kinds carried on the input tuser
	localparam logic [1:0] OP_VEL_CMD = 2'd0;
	localparam logic [1:0] OP_ESTOP   = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	// Result actions carried on the output tuser
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_DRIVE = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	// Motor direction codes
	localparam logic [1:0] DIR_BRAKE   = 2'd0;
	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_LEFT_TRIM  = 3'd0;
	localparam logic [2:0] REG_RIGHT_TRIM = 3'd1;
	localparam logic [2:0] REG_WATCHDOG   = 3'd2;
	localparam logic [2:0] REG_BRAKE_DIST = 3'd3;
	localparam logic [2:0] REG_SLOW_DIST  = 3'd4;

	// Limits and scale factors
	localparam logic signed [7:0] SPEED_MAX  = 8'sd100;
	localparam logic signed [7:0] SPEED_MIN  = -8'sd100;
	localparam logic signed [4:0] TRIM_MAX   = 5'sd10;
	localparam logic signed [4:0] TRIM_MIN   = -5'sd10;
	localparam logic [9:0]        US_PER_MS  = 10'd1000;
	localparam logic [11:0]       PERCENT    = 12'd100;

	// Reset values of the registers
	localparam logic [15:0] WATCHDOG_RESET = 16'd500;
	localparam logic [11:0] BRAKE_RESET    = 12'd15;
	localparam logic [11:0] SLOW_RESET     = 12'd40;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AGE,
		ST_CHECK,
		ST_GMUL,
		ST_GDIV,
		ST_LMUL,
		ST_LDIV,
		ST_RMUL,
		ST_RDIV,
		ST_DONE
	} ddmw_state_t;

endpackage

[rtl/diff_drive_mixer_watchdog.sv]
`timescale 1ns / 1ps

// Differential-drive mixer with command watchdog and obstacle gating.
// Input stream: tuser carries the request kind (velocity command, emergency
// stop, control tick), tdata the speeds, time stamp and obstacle distances.
// Output stream: one result per request; tuser carries the action, tdata the
// per-side direction and speed, the active flag and the held command.
// Configuration: cfg_wr_en / cfg_index / cfg_data write the trims, watchdog,
// brake and slow distances; write only while the block is idle.
// Velocity commands, stops and unused kinds pass from idle straight to the
// done state, which loads the output register. A tick walks a sequencer
// around one shared 8x12 multiplier and one shift-subtract divider that
// yields a quotient bit per cycle: an age check, obstacle scaling when it
// applies, each side in turn, and then the done state, which loads and
// presents the result; a tick that does not drive skips scaling and sides.
// One request at a time: s_tready is high only while idle, so the block takes
// no new request before it is through with the last one.
// A result waits in the output register while the next request is taken; a
// stalled receiver holds the sequencer at its last step until it frees up.
// Reset clears the held command, stamp and active flag and loads the
// register defaults; no result is pending after reset.
module diff_drive_mixer_watchdog import ddmw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: linear_cmd[7:0], angular_cmd[15:8], now_us[63:16],
	//          front_distance[75:64], back_distance[87:76], sensor_ok[88], zero fill
	input  logic [95:0] s_tdata,
	// s_tuser: op[1:0]
	input  logic [1:0]  s_tuser,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: left_dir[1:0], left_speed[8:2], right_dir[10:9], right_speed[17:11],
	//          moving[18], held_linear[26:19], held_angular[34:27], zero fill
	output logic [39:0] m_tdata,
	// m_tuser: action[1:0]
	output logic [1:0]  m_tuser
);

	ddmw_state_t state_q, state_d;

	// Configuration registers
	logic signed [4:0] ltrim_q, rtrim_q;
	logic [15:0]       wd_q;
	logic [11:0]       brake_q, slow_q;

	// Held command state
	logic signed [7:0] lin_q, ang_q;
	logic [47:0]       stamp_q;
	logic              active_q;

	// Latched request
	logic [47:0] now_q;
	logic [11:0] front_q, back_q;
	logic        sok_q;

	// Working registers
	logic [47:0]       diff_q;
	logic              borrow_q;
	logic [26:0]       thr_q;
	logic signed [7:0] g_q;
	logic [19:0]       rem_q;
	logic [7:0]        quo_q;
	logic [2:0]        cnt_q;
	logic              neg_q;
	logic [1:0]        action_q;
	logic [1:0]        ld_q, rd_q;
	logic [6:0]        ls_q, rs_q;

	// Output register
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	// Request fields
	logic signed [7:0] in_lin, in_ang;
	logic [47:0]       in_now;
	logic [11:0]       in_front, in_back;
	logic              in_sok;
	logic              in_fire, out_free;

	// Tick decisions
	logic        expired, stopped, gate_on, brake_hit, slow_hit, need_div;
	logic [11:0] dist_sel;

	// Shared unit signals
	logic [7:0]        mul_a;
	logic [11:0]       mul_b;
	logic [19:0]       product;
	logic [11:0]       div_den;
	logic [19:0]       div_shifted;
	logic              div_ge;
	logic [7:0]        quo_fin;
	logic signed [8:0] side_sum;
	logic [6:0]        factor_l, factor_r, factor_sel;
	logic [6:0]        spd_fin;
	logic [1:0]        dir_fin;
	logic [7:0]        lin_mag;

	function automatic logic signed [4:0] sat_trim(input logic [4:0] raw);
		logic signed [4:0] v;
		v = $signed(raw);
		if (v < TRIM_MIN) begin
			return TRIM_MIN;
		end else if (v > TRIM_MAX) begin
			return TRIM_MAX;
		end
		return v;
	endfunction

	function automatic logic signed [7:0] sat_speed(input logic signed [7:0] v);
		if (v < SPEED_MIN) begin
			return SPEED_MIN;
		end else if (v > SPEED_MAX) begin
			return SPEED_MAX;
		end
		return v;
	endfunction

	// Unpack the request
	assign in_lin   = $signed(s_tdata[7:0]);
	assign in_ang   = $signed(s_tdata[15:8]);
	assign in_now   = s_tdata[63:16];
	assign in_front = s_tdata[75:64];
	assign in_back  = s_tdata[87:76];
	assign in_sok   = s_tdata[88];

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Watchdog and obstacle decisions
	always_comb begin
		expired   = (stamp_q == 48'd0) ||
			(!borrow_q && ((diff_q[47:27] != 21'd0) || (diff_q[26:0] >= thr_q)));
		stopped   = expired || (lin_q == 8'sd0 && ang_q == 8'sd0);
		dist_sel  = (lin_q > 8'sd0) ? front_q : back_q;
		gate_on   = sok_q && (lin_q != 8'sd0);
		brake_hit = dist_sel < brake_q;
		slow_hit  = dist_sel < slow_q;
		need_div  = gate_on && !brake_hit && slow_hit;
	end

	// Trim factors in percent
	assign factor_l = 7'(8'sd100 + 8'(ltrim_q));
	assign factor_r = 7'(8'sd100 + 8'(rtrim_q));
	assign lin_mag  = lin_q[7] ? 8'(-lin_q) : 8'(lin_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (s_tuser == OP_TICK) ? ST_AGE : ST_DONE;
				end
			end
			ST_AGE: state_d = ST_CHECK;
			ST_CHECK: begin
				if (stopped) begin
					state_d = ST_DONE;
				end else if (need_div) begin
					state_d = ST_GMUL;
				end else begin
					state_d = ST_LMUL;
				end
			end
			ST_GMUL: state_d = ST_GDIV;
			ST_GDIV: begin
				if (cnt_q == 3'd0) begin
					state_d = ST_LMUL;
				end
			end
			ST_LMUL: state_d = ST_LDIV;
			ST_LDIV: begin
				if (cnt_q == 3'd0) begin
					state_d = ST_RMUL;
				end
			end
			ST_RMUL: state_d = ST_RDIV;
			ST_RDIV: begin
				if (cnt_q == 3'd0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Shared unit operand selection
	always_comb begin
		s_tready   = 1'b0;
		mul_a      = lin_mag;
		mul_b      = dist_sel;
		factor_sel = factor_l;
		side_sum   = 9'(g_q) + 9'(ang_q);
		div_den    = PERCENT;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_LMUL: begin
				side_sum   = 9'(g_q) + 9'(ang_q);
				factor_sel = factor_l;
				mul_a      = side_sum[8] ? 8'(-side_sum) : 8'(side_sum);
				mul_b      = 12'(factor_sel);
			end
			ST_RMUL: begin
				side_sum   = 9'(g_q) - 9'(ang_q);
				factor_sel = factor_r;
				mul_a      = side_sum[8] ? 8'(-side_sum) : 8'(side_sum);
				mul_b      = 12'(factor_sel);
			end
			ST_GDIV: div_den = slow_q;
			default: begin
			end
		endcase
	end

	// Multiplier and one divide step
	always_comb begin
		product     = 20'(mul_a) * 20'(mul_b);
		div_shifted = 20'(div_den) << cnt_q;
		div_ge      = rem_q >= div_shifted;
		quo_fin     = {quo_q[6:0], div_ge};
		spd_fin     = (quo_fin > 8'd100) ? 7'd100 : quo_fin[6:0];
		if (quo_fin == 8'd0) begin
			dir_fin = DIR_BRAKE;
		end else if (neg_q) begin
			dir_fin = DIR_REVERSE;
		end else begin
			dir_fin = DIR_FORWARD;
		end
	end

	// Sequencer, configuration and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ltrim_q    <= 5'sd0;
			rtrim_q    <= 5'sd0;
			wd_q       <= WATCHDOG_RESET;
			brake_q    <= BRAKE_RESET;
			slow_q     <= SLOW_RESET;
			lin_q      <= 8'sd0;
			ang_q      <= 8'sd0;
			stamp_q    <= 48'd0;
			active_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Take configuration writes
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LEFT_TRIM:  ltrim_q <= sat_trim(cfg_data[4:0]);
					REG_RIGHT_TRIM: rtrim_q <= sat_trim(cfg_data[4:0]);
					REG_WATCHDOG:   wd_q    <= cfg_data;
					REG_BRAKE_DIST: brake_q <= cfg_data[11:0];
					REG_SLOW_DIST:  slow_q  <= cfg_data[11:0];
					default: begin
					end
				endcase
			end

			// Store or clear the command on acceptance
			if (in_fire) begin
				case (s_tuser)
					OP_VEL_CMD: begin
						lin_q   <= sat_speed(in_lin);
						ang_q   <= sat_speed(in_ang);
						stamp_q <= in_now;
					end
					OP_ESTOP: begin
						lin_q    <= 8'sd0;
						ang_q    <= 8'sd0;
						stamp_q  <= 48'd0;
						active_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			// Update the active flag from the tick decision
			if (state_q == ST_CHECK) begin
				if (stopped) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
				end
			end

			// Load the next result, or drop the current one once taken
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					now_q   <= in_now;
					front_q <= in_front;
					back_q  <= in_back;
					sok_q   <= in_sok;
					ld_q    <= DIR_BRAKE;
					ls_q    <= 7'd0;
					rd_q    <= DIR_BRAKE;
					rs_q    <= 7'd0;
					action_q <= (s_tuser == OP_ESTOP) ? ACT_STOP : ACT_NONE;
				end
			end
			ST_AGE: begin
				{borrow_q, diff_q} <= {1'b0, now_q} - {1'b0, stamp_q};
				thr_q <= (27'(wd_q) + 27'd1) * 27'(US_PER_MS);
			end
			ST_CHECK: begin
				if (stopped) begin
					action_q <= active_q ? ACT_STOP : ACT_NONE;
				end else begin
					action_q <= ACT_DRIVE;
				end
				if (gate_on && brake_hit) begin
					g_q <= 8'sd0;
				end else begin
					g_q <= lin_q;
				end
			end
			ST_GMUL, ST_LMUL, ST_RMUL: begin
				rem_q <= product;
				quo_q <= 8'd0;
				cnt_q <= 3'd7;
				neg_q <= (state_q == ST_GMUL) ? lin_q[7] : side_sum[8];
			end
			ST_GDIV, ST_LDIV, ST_RDIV: begin
				if (div_ge) begin
					rem_q <= rem_q - div_shifted;
				end
				quo_q <= quo_fin;
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					case (state_q)
						ST_GDIV: g_q <= neg_q ? -$signed(quo_fin) : $signed(quo_fin);
						ST_LDIV: begin
							ld_q <= dir_fin;
							ls_q <= spd_fin;
						end
						default: begin
							rd_q <= dir_fin;
							rs_q <= spd_fin;
						end
					endcase
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {5'd0, ang_q, lin_q, active_q, rs_q, rd_q, ls_q, ld_q};
					m_tuser_q <= action_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[dv/ddmw_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and register write ports, keeps its own copy
// of the mixer state and compares every result with the oldest prediction.
module ddmw_checker import ddmw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] ldir;
		logic [6:0] lspd;
		logic [1:0] rdir;
		logic [6:0] rspd;
		logic       moving;
		logic [7:0] hlin;
		logic [7:0] hang;
	} drive_result_t;

	drive_result_t pending_drives[$];

	// Register copies
	int          left_trim;
	int          right_trim;
	logic [15:0] watchdog_ms;
	logic [11:0] brake_cm;
	logic [11:0] slow_cm;

	// Held command and watchdog state
	int          held_lin;
	int          held_ang;
	logic [47:0] stamp_us;
	logic        active;

	function automatic int clamp(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int obstacle_gate(int lin, logic [11:0] dist_cm);
		int d;
		int s;
		d = dist_cm;
		s = slow_cm;
		if (dist_cm < brake_cm)
			return 0;
		if (dist_cm < slow_cm)
			return (lin * d) / s;
		return lin;
	endfunction

	// Trim one side, clamp it and split into direction and magnitude
	function automatic void drive_side(int v, int trim, output logic [1:0] dir,
			output logic [6:0] spd);
		int pct;
		pct = PERCENT;
		v = (v * (pct + trim)) / pct;
		v = clamp(v, SPEED_MIN, SPEED_MAX);
		dir = v > 0 ? DIR_FORWARD : (v < 0 ? DIR_REVERSE : DIR_BRAKE);
		spd = 7'(v < 0 ? -v : v);
	endfunction

	// Work out the result of one request and advance the held state
	function automatic drive_result_t mix_and_gate(logic [1:0] op, logic [95:0] d);
		logic signed [7:0] lin;
		logic signed [7:0] ang;
		logic [47:0]       now;
		logic [11:0]       front;
		logic [11:0]       back;
		logic              sok;
		logic              expired;
		int                g;
		drive_result_t     r;
		lin   = d[7:0];
		ang   = d[15:8];
		now   = d[63:16];
		front = d[75:64];
		back  = d[87:76];
		sok   = d[88];
		r     = '0;
		case (op)
			OP_VEL_CMD: begin
				held_lin = clamp(lin, SPEED_MIN, SPEED_MAX);
				held_ang = clamp(ang, SPEED_MIN, SPEED_MAX);
				stamp_us = now;
			end
			OP_ESTOP: begin
				held_lin = 0;
				held_ang = 0;
				stamp_us = '0;
				active   = 1'b0;
				r.action = ACT_STOP;
			end
			OP_TICK: begin
				expired = (stamp_us == '0) ||
					(now >= stamp_us && (now - stamp_us) / US_PER_MS > watchdog_ms);
				if (expired || (held_lin == 0 && held_ang == 0)) begin
					// stop only if the motors were running
					if (active) begin
						r.action = ACT_STOP;
						active   = 1'b0;
					end
				end else begin
					g = held_lin;
					if (sok && g > 0)
						g = obstacle_gate(g, front);
					else if (sok && g < 0)
						g = obstacle_gate(g, back);
					drive_side(g + held_ang, left_trim, r.ldir, r.lspd);
					drive_side(g - held_ang, right_trim, r.rdir, r.rspd);
					active   = 1'b1;
					r.action = ACT_DRIVE;
				end
			end
			default: ;
		endcase
		r.moving = active;
		r.hlin   = held_lin[7:0];
		r.hang   = held_ang[7:0];
		return r;
	endfunction

	task automatic report(string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// Compare results, then queue the prediction of any new request
	always @(posedge clk or negedge arst_n) begin : track
		drive_result_t want;
		if (!arst_n) begin
			left_trim   = 0;
			right_trim  = 0;
			watchdog_ms = WATCHDOG_RESET;
			brake_cm    = BRAKE_RESET;
			slow_cm     = SLOW_RESET;
			held_lin    = 0;
			held_ang    = 0;
			stamp_us    = '0;
			active      = 1'b0;
			mismatches  = 0;
			pending_drives.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_drives.size() == 0) begin
					report($sformatf("result with no request pending, action %0d", m_tuser));
				end else begin
					want = pending_drives.pop_front();
					check_field("action", m_tuser, want.action);
					check_field("left_dir", m_tdata[1:0], want.ldir);
					check_field("left_speed", m_tdata[8:2], want.lspd);
					check_field("right_dir", m_tdata[10:9], want.rdir);
					check_field("right_speed", m_tdata[17:11], want.rspd);
					check_field("moving", m_tdata[18], want.moving);
					check_field("held_linear", $signed(m_tdata[26:19]), $signed(want.hlin));
					check_field("held_angular", $signed(m_tdata[34:27]), $signed(want.hang));
				end
			end
			if (s_tvalid && s_tready)
				pending_drives.push_back(mix_and_gate(s_tuser, s_tdata));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LEFT_TRIM:  left_trim   = clamp(signed'(cfg_data[4:0]), TRIM_MIN, TRIM_MAX);
					REG_RIGHT_TRIM: right_trim  = clamp(signed'(cfg_data[4:0]), TRIM_MIN, TRIM_MAX);
					REG_WATCHDOG:   watchdog_ms = cfg_data;
					REG_BRAKE_DIST: brake_cm    = cfg_data[11:0];
					REG_SLOW_DIST:  slow_cm     = cfg_data[11:0];
					default: ;
				endcase
			end
		end
		pending = pending_drives.size();
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import ddmw_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	int          mismatches;
	int          pending;

	// Idling percentages of sender and receiver
	int tx_idle_pct = 11;
	int rx_idle_pct = 58;

	// Mirror of the settings, used to aim the stimulus
	int          cur_wd    = 500;
	int          cur_brake = 15;
	int          cur_slow  = 40;
	logic [47:0] cmd_stamp = '0;
	logic [47:0] clock_us  = 48'd10_000_000;

	always #5 clk = ~clk;

	diff_drive_mixer_watchdog i_dut (.*);

	ddmw_checker i_checker (.*);

	// Stall the result stream at random
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

	initial begin
		#20_000_000;
		$display("FAIL diff_drive_mixer_watchdog");
		$finish;
	end

	// Offer one request, idling first at random; return once it is taken
	task automatic send(logic [1:0] op, logic signed [7:0] lin, logic signed [7:0] ang,
			logic [47:0] now, logic [11:0] front, logic [11:0] back, logic sok);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, sok, back, front, now, ang, lin};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and hold off until every result is back
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Load all registers; unused upper bits carry noise
	task automatic load_settings(int lt, int rt, int wd, int br, int sl);
		logic [15:0] noise;
		noise = 16'($urandom);
		write_reg(REG_LEFT_TRIM, {noise[15:5], lt[4:0]});
		noise = 16'($urandom);
		write_reg(REG_RIGHT_TRIM, {noise[15:5], rt[4:0]});
		write_reg(REG_WATCHDOG, wd[15:0]);
		noise = 16'($urandom);
		write_reg(REG_BRAKE_DIST, {noise[15:12], br[11:0]});
		noise = 16'($urandom);
		write_reg(REG_SLOW_DIST, {noise[15:12], sl[11:0]});
		write_reg(REG_SLOW_DIST + 3'd1 + 3'($urandom_range(0, 2)), 16'($urandom));
		cur_wd    = wd[15:0];
		cur_brake = br[11:0];
		cur_slow  = sl[11:0];
	endtask

	function automatic logic signed [7:0] pick_speed();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'($urandom_range(0, 200) - 100);
			5, 6:          return 8'($urandom);
			7:             return 0;
			8:             return $urandom_range(0, 1) ? 100 : -100;
			default:       return $urandom_range(0, 1) ? 127 : -128;
		endcase
	endfunction

	// Aim distances at the brake and slow thresholds
	function automatic logic [11:0] pick_range();
		int v;
		case ($urandom_range(0, 4))
			0:       v = $urandom_range(0, 4095);
			1:       v = cur_brake == 0 ? 0 : $urandom_range(0, cur_brake - 1);
			2:       v = $urandom_range(cur_brake, cur_slow);
			3:       v = cur_slow + $urandom_range(0, 2) - 1;
			default: v = $urandom_range(0, 1) ? 4095 : $urandom_range(cur_slow, 4095);
		endcase
		return 12'(v < 0 ? 0 : (v > 4095 ? 4095 : v));
	endfunction

	function automatic logic [47:0] command_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 19))
			0: return '0;
			1: return r[47:0];
			default: begin
				clock_us = clock_us + $urandom_range(1, 3_000_000);
				return clock_us;
			end
		endcase
	endfunction

	// Place ticks around the watchdog limit of the held command
	function automatic logic [47:0] tick_time();
		logic [47:0] span;
		logic [63:0] r;
		span = cur_wd * 48'd1000;
		r    = {$urandom, $urandom};
		case ($urandom_range(0, 19))
			12, 13, 14: return cmd_stamp + span + 48'd1000 + $urandom_range(0, 100_000);
			15:         return cmd_stamp + span + 48'd999;
			16:         return cmd_stamp + span + 48'd1000;
			17:         return cmd_stamp - $urandom_range(1, 1000);
			18:         return r[47:0];
			19:         return cmd_stamp;
			default:    return cmd_stamp + $urandom_range(0, span + 999);
		endcase
	endfunction

	task automatic random_item;
		logic [1:0]        op;
		logic signed [7:0] lin;
		logic signed [7:0] ang;
		logic [47:0]       now;
		logic [63:0]       r;
		int                pick;
		pick = $urandom_range(0, 99);
		lin  = pick_speed();
		ang  = pick_speed();
		r    = {$urandom, $urandom};
		now  = r[47:0];
		if (pick < 25) begin
			op        = OP_VEL_CMD;
			now       = command_time();
			cmd_stamp = now;
		end else if (pick < 88) begin
			op  = OP_TICK;
			now = tick_time();
		end else if (pick < 95) begin
			op = OP_ESTOP;
		end else begin
			op = OP_UNUSED;
		end
		send(op, lin, ang, now, pick_range(), pick_range(), $urandom_range(0, 9) != 0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings
		send(OP_TICK, 0, 0, 48'd5000, 100, 100, 1);
		send(OP_VEL_CMD, 127, -128, 48'd0, 0, 0, 0);
		send(OP_TICK, 0, 0, 48'd1000, 4095, 4095, 1);
		send(OP_VEL_CMD, 60, 25, 48'd1_000_000, 4095, 4095, 1);
		send(OP_TICK, 0, 0, 48'd1_000_000, 0, 0, 0);
		send(OP_TICK, 0, 0, 48'd999_000, 4095, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_100_000, 14, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_100_000, 15, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_100_000, 39, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_100_000, 40, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_500_999, 4095, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_501_000, 4095, 0, 1);
		send(OP_TICK, 0, 0, 48'd1_501_000, 4095, 0, 1);
		send(OP_VEL_CMD, -100, 7, 48'd2_000_000, 0, 0, 0);
		send(OP_TICK, 0, 0, 48'd2_000_100, 0, 20, 1);
		send(OP_TICK, 0, 0, 48'd2_000_200, 4095, 3, 1);
		send(OP_VEL_CMD, 100, 100, 48'd3_000_000, 0, 0, 1);
		send(OP_TICK, 0, 0, 48'd3_000_000, 4095, 4095, 0);
		send(OP_VEL_CMD, -128, 127, 48'hFFFF_FFFF_FFFF, 4095, 4095, 1);
		send(OP_TICK, -1, -1, 48'hFFFF_FFFF_FFFF, 4095, 4095, 1);
		send(OP_VEL_CMD, 0, 0, 48'd4_000_000, 0, 0, 0);
		send(OP_TICK, 0, 0, 48'd4_000_000, 4095, 4095, 1);
		send(OP_UNUSED, -1, -1, 48'hFFFF_FFFF_FFFF, 4095, 4095, 1);
		send(OP_VEL_CMD, 50, -50, 48'd5_000_000, 0, 0, 0);
		send(OP_TICK, 0, 0, 48'd5_000_000, 4095, 4095, 1);
		send(OP_ESTOP, 0, 0, 48'd5_000_000, 0, 0, 0);
		send(OP_TICK, 0, 0, 48'd5_000_000, 4095, 4095, 1);

		// Random phases, each under its own settings; the idling changes every two phases
		for (int phase = 0; phase < 6; phase++) begin
			tx_idle_pct = phase < 2 ? 11 : (phase < 4 ? 58 : 0);
			rx_idle_pct = phase < 2 ? 58 : (phase < 4 ? 11 : 0);
			drain();
			case (phase)
				0: load_settings(0, 0, 500, 15, 40);
				1: load_settings(10, -10, 0, 0, 4095);
				2: load_settings(15, -16, 65535, 4095, 1);
				3: load_settings(-3, 7, 2, 100, 0);
				4: load_settings($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
						$urandom_range(0, 50), 200, 50);
				default: load_settings($urandom, $urandom, $urandom_range(0, 65535),
						$urandom_range(0, 4095), $urandom_range(0, 4095));
			endcase
			repeat (325) random_item();
		end
		drain();

		if (mismatches == 0 && pending == 0)
			$display("PASS diff_drive_mixer_watchdog");
		else
			$display("FAIL diff_drive_mixer_watchdog");
		$finish;
	end

endmodule
